// File: hdl/fatlb_pkg.sv
// Shared types and constants for the fully associative LRU TLB.
package fatlb_pkg;

    localparam int PAGE_W = 20;
    localparam int PID_W  = 16;
    localparam int KIND_W = 2;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    // One translation entry as it moves along the recency chain
    typedef struct packed {
        logic              valid;
        logic [PAGE_W-1:0] tag;
        logic [PAGE_W-1:0] frame;
    } t_entry;

    // Per-cell control from the chain controller
    typedef struct packed {
        logic shift;  // take the left neighbour's entry
        logic flush;  // drop the valid bit (process change)
        logic inval;  // drop the valid bit (remove hit)
    } t_cell_ctl;

endpackage

// File: hdl/fully_associative_lru_tlb_unit.sv
// Fully associative TLB with least-recently-used replacement.
//
// Requests arrive on i_in_valid / o_in_stall with kind, process id, virtual
// page and physical page. A read looks up the page and returns hit and frame
// on o_out_valid / i_out_stall; writes and removes return nothing. A request
// whose process id differs from the current owner flushes every entry first.
// The unused kind is accepted and dropped.
// Entries sit in a chain of cells ordered by recency: a touched entry moves
// to the front and the cells before it each hand their entry one place back,
// so the least recently used valid entry is always the last valid cell.
// Each request is first accepted into the request registers, then all tags
// are compared and the chain updated; no new request is taken while one is
// in its update cycle. A read result appears in the cycle after the update.
// The output register holds a result while i_out_stall is high; a further
// request may still be accepted, and a read then waits in its update cycle
// until the register frees.
// Synchronous reset clears all valid bits, the owner process and the output valid.
module fully_associative_lru_tlb_unit
    import fatlb_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [PID_W-1:0]  i_process_id,
    input  logic [PAGE_W-1:0] i_virtual_page,
    input  logic [PAGE_W-1:0] i_physical_page,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_hit,
    output logic [PAGE_W-1:0] o_frame
);

    localparam int IDW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state            r_state, n_state;
    logic [KIND_W-1:0] r_kind;
    logic [PID_W-1:0]  r_pid;
    logic [PAGE_W-1:0] r_vpage;
    logic [PAGE_W-1:0] r_ppage;
    logic [PID_W-1:0]  r_owner, n_owner;
    logic              r_out_valid, n_out_valid;
    logic              r_hit, n_hit;
    logic [PAGE_W-1:0] r_frame, n_frame;

    t_entry            w_ent[ENTRIES];
    logic [IDW-1:0]    w_id[ENTRIES];
    t_entry            w_left[ENTRIES];
    logic [IDW-1:0]    w_left_id[ENTRIES];
    t_cell_ctl         w_ctl[ENTRIES];

    logic               w_accept;
    logic               w_go;
    logic               w_flush;
    logic [ENTRIES-1:0] w_live;
    logic [ENTRIES-1:0] w_hit;
    logic               w_any_hit;
    logic [PAGE_W-1:0]  w_hit_frame;
    logic [ENTRIES-1:0] w_free_id;
    logic               w_any_free;
    logic [IDW-1:0]     w_low_id;
    logic [ENTRIES-1:0] w_vic;
    logic [ENTRIES-1:0] w_touch;
    logic [ENTRIES-1:0] w_shift;
    logic               w_acc;
    logic [IDW-1:0]     w_touch_id;
    t_entry             w_front;

    // Cell chain
    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        fatlb_cell #(
            .IDW   (IDW),
            .INDEX (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl[k]),
            .i_left    (w_left[k]),
            .i_left_id (w_left_id[k]),
            .o_entry   (w_ent[k]),
            .o_id      (w_id[k])
        );
    end

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_flush  = (r_pid != r_owner);
    assign w_go     = (r_state == S_EXEC) &&
                      ((r_kind != KIND_READ) || !r_out_valid || !i_out_stall);

    // Parallel tag compare; at most one live entry matches
    always_comb begin
        w_hit_frame = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            w_live[k] = w_ent[k].valid && !w_flush;
            w_hit[k]  = w_live[k] && (w_ent[k].tag == r_vpage);
            if (w_hit[k]) begin
                w_hit_frame = w_hit_frame | w_ent[k].frame;
            end
        end
        w_any_hit = |w_hit;
    end

    // Free slots by entry index, lowest index first
    always_comb begin
        for (int j = 0; j < ENTRIES; j++) begin
            w_free_id[j] = 1'b0;
            for (int k = 0; k < ENTRIES; k++) begin
                if (!w_live[k] && (w_id[k] == IDW'(j))) begin
                    w_free_id[j] = 1'b1;
                end
            end
        end
        w_any_free = |w_free_id;
        w_low_id   = '0;
        for (int j = ENTRIES - 1; j >= 0; j--) begin
            if (w_free_id[j]) begin
                w_low_id = IDW'(j);
            end
        end
    end

    // Victim: lowest free index, else the tail cell (least recently used)
    always_comb begin
        for (int k = 0; k < ENTRIES; k++) begin
            if (w_any_free) begin
                w_vic[k] = !w_live[k] && (w_id[k] == w_low_id);
            end else begin
                w_vic[k] = (k == ENTRIES - 1);
            end
        end
    end

    // Which cell moves to the front
    always_comb begin
        w_touch = '0;
        if (w_go) begin
            unique case (r_kind)
                KIND_READ:  w_touch = w_hit;
                KIND_WRITE: w_touch = w_any_hit ? w_hit : w_vic;
                default:    w_touch = '0;
            endcase
        end
    end

    // Cells at or before the touched position shift back by one
    always_comb begin
        w_acc      = 1'b0;
        w_touch_id = '0;
        for (int k = ENTRIES - 1; k >= 0; k--) begin
            w_acc      = w_acc | w_touch[k];
            w_shift[k] = w_acc;
            if (w_touch[k]) begin
                w_touch_id = w_touch_id | w_id[k];
            end
        end
    end

    // New front entry
    always_comb begin
        w_front.valid = 1'b1;
        w_front.tag   = r_vpage;
        w_front.frame = (r_kind == KIND_READ) ? w_hit_frame : r_ppage;
    end

    // Neighbour hand-off and per-cell control
    always_comb begin
        for (int k = 0; k < ENTRIES; k++) begin
            if (k == 0) begin
                w_left[k]    = w_front;
                w_left_id[k] = w_touch_id;
            end else begin
                w_left[k]       = w_ent[k-1];
                w_left[k].valid = w_live[k-1];
                w_left_id[k]    = w_id[k-1];
            end
            w_ctl[k].shift = w_shift[k];
            w_ctl[k].flush = w_go && w_flush;
            w_ctl[k].inval = w_go && (r_kind == KIND_REMOVE) && w_hit[k];
        end
    end

    // Next state and result register
    always_comb begin
        n_state     = r_state;
        n_owner     = r_owner;
        n_out_valid = r_out_valid && i_out_stall;
        n_hit       = r_hit;
        n_frame     = r_frame;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_kind != KIND_READ) && (i_kind != KIND_WRITE)
                    && (i_kind != KIND_REMOVE)) begin
                    n_state = S_IDLE;
                end else if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_go) begin
                    n_state = S_IDLE;
                    n_owner = r_pid;
                    if (r_kind == KIND_READ) begin
                        n_out_valid = 1'b1;
                        n_hit       = w_any_hit;
                        n_frame     = w_hit_frame;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State, request and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_owner     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_owner     <= n_owner;
            r_out_valid <= n_out_valid;
        end
        if (w_accept) begin
            r_kind  <= i_kind;
            r_pid   <= i_process_id;
            r_vpage <= i_virtual_page;
            r_ppage <= i_physical_page;
        end
        r_hit   <= n_hit;
        r_frame <= n_frame;
    end

    assign o_in_stall  = (r_state == S_EXEC);
    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_frame     = r_frame;

    // Checks
    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> $onehot0(w_hit))
        else $error("more than one live entry matches the page");

    a_victim_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && (r_kind == KIND_WRITE) && !w_any_hit) |-> $onehot(w_vic))
        else $error("write miss without exactly one victim");

    a_no_stall_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EXEC) && (r_kind != KIND_READ)) |=> (r_state == S_IDLE))
        else $error("write or remove held in update cycle");

    a_miss_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit) |-> (o_frame == '0))
        else $error("miss returned a non-zero frame");

endmodule

// File: hdl/fatlb_cell.sv
// One slot of the recency-ordered entry chain.
module fatlb_cell
    import fatlb_pkg::*;
#(
    parameter int IDW   = 4,
    parameter int INDEX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_cell_ctl      i_ctl,
    input  t_entry         i_left,
    input  logic [IDW-1:0] i_left_id,
    output t_entry         o_entry,
    output logic [IDW-1:0] o_id
);

    logic              r_valid;
    logic [IDW-1:0]    r_id;
    logic [PAGE_W-1:0] r_tag;
    logic [PAGE_W-1:0] r_frame;

    // Valid bit and entry identity; each cell starts with its own index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_id    <= IDW'(INDEX);
        end else if (i_ctl.shift) begin
            r_valid <= i_left.valid;
            r_id    <= i_left_id;
        end else if (i_ctl.flush || i_ctl.inval) begin
            r_valid <= 1'b0;
        end
    end

    // Tag and frame follow the shift
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_tag   <= i_left.tag;
            r_frame <= i_left.frame;
        end
    end

    assign o_entry = '{valid: r_valid, tag: r_tag, frame: r_frame};
    assign o_id    = r_id;

endmodule
